// ----- hw/rtl/page_split_scatter_gather_builder_defines.svh -----
// Assertion macros shared by the page-split scatter-gather builder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PAGE_SPLIT_SCATTER_GATHER_BUILDER_DEFINES_SVH
`define PAGE_SPLIT_SCATTER_GATHER_BUILDER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define PSSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PSSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/pssg_pkg.sv -----
// Package for the page-split scatter-gather builder: widths, codes, types.
// No dependencies.
package pssg_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned PAGE_OFF_W   = 12;
  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [LEN_W-1:0] PAGE_BYTES = LEN_W'(13'h1000);

  // Input and output beat widths, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_LIMIT   = 2'd2
  } pssg_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } pssg_state_e;

  // One computed segment plus the request state that follows it
  typedef struct packed {
    logic [LEN_W-1:0]  take;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] next_rem;
    logic              last;
    pssg_status_e      status;
  } pssg_seg_t;

endpackage

// ----- hw/rtl/pssg_seg_unit.sv -----
// Shared segment unit: cuts one segment off the request at the page boundary.
// Depends on pssg_pkg.
module pssg_seg_unit (
  input  logic [pssg_pkg::ADDR_W-1:0] addr_i,
  input  logic [pssg_pkg::ADDR_W-1:0] rem_i,
  input  logic [pssg_pkg::CNT_W-1:0]  cnt_i,
  output pssg_pkg::pssg_seg_t         seg_o
);

  logic [pssg_pkg::LEN_W-1:0]  avail;
  logic [pssg_pkg::LEN_W-1:0]  take;
  logic [pssg_pkg::ADDR_W-1:0] next_rem;
  logic                        at_limit;
  logic                        last;

  // Bytes left in the current page, 1 to 4096
  assign avail = pssg_pkg::PAGE_BYTES -
                 {1'b0, addr_i[pssg_pkg::PAGE_OFF_W-1:0]};

  // Segment length: lesser of page remainder and request remainder
  assign take = (rem_i < {{(pssg_pkg::ADDR_W-pssg_pkg::LEN_W){1'b0}}, avail}) ?
                rem_i[pssg_pkg::LEN_W-1:0] : avail;

  assign next_rem = rem_i - {{(pssg_pkg::ADDR_W-pssg_pkg::LEN_W){1'b0}}, take};
  assign at_limit = (cnt_i == pssg_pkg::CNT_W'(pssg_pkg::MAX_SEGMENTS - 1));
  assign last     = (next_rem == '0) || at_limit;

  always_comb begin
    seg_o.take      = take;
    seg_o.next_addr = addr_i + {{(pssg_pkg::ADDR_W-pssg_pkg::LEN_W){1'b0}}, take};
    seg_o.next_rem  = next_rem;
    seg_o.last      = last;
    seg_o.status    = (last && (next_rem != '0)) ? pssg_pkg::STAT_LIMIT :
                                                   pssg_pkg::STAT_OK;
  end

endmodule

// ----- hw/rtl/page_split_scatter_gather_builder.sv -----
// Top level of the page-split scatter-gather builder.
// Depends on pssg_pkg, pssg_seg_unit and the shared assertion macros.
//
//  channel   dir  tdata (low bit up)                       tlast  tuser
//  s_axis    in   start_address[31:0], byte_count[31:0]    -      -
//  m_axis    out  segment_address[31:0], segment_length    last   status
//                 [12:0], zero pad to 48 bits
//
// A request is taken only when the sequencer is idle. The accept cycle loads
// it; the shared segment unit then yields one segment per cycle while the
// output register is free, up to MAX_SEGMENTS (16) segments per request; an
// invalid request yields a single beat. The sequencer stalls while the output
// register holds a beat that m_axis does not take; the next request may be
// taken while the final segment waits.
// Reset (rst_ni low, asynchronous) returns the block to idle with no beat
// pending.
module page_split_scatter_gather_builder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_address[31:0], byte_count[63:32]
  input  logic [pssg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // segment_address[31:0], segment_length[44:32], zeros[47:45]
  output logic [pssg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  // status[1:0]
  output logic [1:0]                         m_axis_tuser
);

  `include "page_split_scatter_gather_builder_defines.svh"

  pssg_pkg::pssg_state_e        state_q, state_d;
  logic [pssg_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [pssg_pkg::ADDR_W-1:0]  rem_q, rem_d;
  logic [pssg_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         inv_q, inv_d;

  logic                         ovalid_q, ovalid_d;
  logic [pssg_pkg::ADDR_W-1:0]  oaddr_q, oaddr_d;
  logic [pssg_pkg::LEN_W-1:0]   olen_q, olen_d;
  logic                         olast_q, olast_d;
  pssg_pkg::pssg_status_e       ostat_q, ostat_d;

  logic                         in_beat;
  logic                         out_free;
  pssg_pkg::pssg_seg_t          seg;

  assign s_axis_tready = (state_q == pssg_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  pssg_seg_unit u_seg (
    .addr_i (addr_q),
    .rem_i  (rem_q),
    .cnt_i  (cnt_q),
    .seg_o  (seg)
  );

  // Sequencer: load request, then emit one segment per free output slot
  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    inv_d    = inv_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    oaddr_d  = oaddr_q;
    olen_d   = olen_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;
    case (state_q)
      pssg_pkg::ST_IDLE: begin
        if (in_beat) begin
          addr_d  = s_axis_tdata[31:0];
          rem_d   = s_axis_tdata[63:32];
          cnt_d   = '0;
          inv_d   = (s_axis_tdata[31:0] == '0) || (s_axis_tdata[63:32] == '0);
          state_d = pssg_pkg::ST_RUN;
        end
      end
      pssg_pkg::ST_RUN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (inv_q) begin
            oaddr_d = '0;
            olen_d  = '0;
            olast_d = 1'b1;
            ostat_d = pssg_pkg::STAT_INVALID;
            state_d = pssg_pkg::ST_IDLE;
          end else begin
            oaddr_d = addr_q;
            olen_d  = seg.take;
            olast_d = seg.last;
            ostat_d = seg.status;
            addr_d  = seg.next_addr;
            rem_d   = seg.next_rem;
            cnt_d   = cnt_q + pssg_pkg::CNT_W'(1);
            if (seg.last) begin
              state_d = pssg_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = pssg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pssg_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Request and output payload
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    inv_q   <= inv_d;
    oaddr_q <= oaddr_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(pssg_pkg::OUT_DATA_W-pssg_pkg::ADDR_W-pssg_pkg::LEN_W){1'b0}},
                          olen_q, oaddr_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ostat_q;

  // Checks
  `PSSG_ASSERT(a_busy_after_req, in_beat |=> !s_axis_tready, "request not held")
  `PSSG_ASSERT(a_mid_status_ok,
               (m_axis_tvalid && !m_axis_tlast) |-> (ostat_q == pssg_pkg::STAT_OK),
               "non-final beat with status")
  `PSSG_ASSERT(a_invalid_shape,
               (m_axis_tvalid && (ostat_q == pssg_pkg::STAT_INVALID)) |->
               (m_axis_tlast && (olen_q == '0) && (oaddr_q == '0)),
               "malformed invalid beat")
  `PSSG_ASSERT(a_len_range,
               (m_axis_tvalid && (ostat_q != pssg_pkg::STAT_INVALID)) |->
               ((olen_q != '0) && (olen_q <= pssg_pkg::PAGE_BYTES)),
               "segment length out of range")

endmodule
